FILE: hdl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int DIGIT_COUNT_DEFAULT = 10;
  localparam int QUEUE_DEPTH         = 2;

  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;

  // floor(v / 10) == (v * DIV10_MAGIC) >> DIV10_SHIFT for every 32-bit v
  localparam logic [VALUE_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int                 DIV10_SHIFT = 35;

  // ASCII '0', kept to the six low bits of the character code
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONVERT,
    FRONT_PUSH
  } front_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: hdl/b2da_if.sv
// ----------------------------------------------------------------------------
// b2da_value_if / b2da_char_if
// Valid/ready channels for input values and output digit characters.
// ----------------------------------------------------------------------------
interface b2da_value_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface b2da_char_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_char;
  logic       last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink (input valid, input digit_char, input last, output ready);
endinterface

FILE: hdl/b2da_fifo.sv
// ----------------------------------------------------------------------------
// b2da_fifo
// Small register queue between the conversion front and the emit back.
// ----------------------------------------------------------------------------
module b2da_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = b2da_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        wr_data,
  input  logic                    pop,
  output logic [WIDTH-1:0]        rd_data,
  output b2da_pkg::queue_status_t status
);
  import b2da_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.empty = (fill == '0);
  assign rd_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !status.full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !status.empty)
    else $error("queue read while empty");

endmodule

FILE: hdl/b2da_front.sv
// ----------------------------------------------------------------------------
// b2da_front
// Accept a value, peel off decimal digits low first, find the top digit.
// ----------------------------------------------------------------------------
module b2da_front #(
  parameter int DIGIT_COUNT = b2da_pkg::DIGIT_COUNT_DEFAULT,
  parameter int REC_W       = 4 * DIGIT_COUNT + $clog2(DIGIT_COUNT + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  b2da_value_if.sink              values,
  input  b2da_pkg::queue_status_t status,
  output logic                    push,
  output logic [REC_W-1:0]        rec
);
  import b2da_pkg::*;

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int CNT_W = $clog2(DIGIT_COUNT + 1);

  front_state_t         state;
  front_state_t         state_next;
  logic [VALUE_W-1:0]   rest;
  logic [IDX_W-1:0]     k;
  logic [CNT_W-1:0]     top_count;
  logic [DIGIT_W-1:0]   digs [DIGIT_COUNT];

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [DIGIT_W-1:0]   ten_q_lo;
  logic [DIGIT_W-1:0]   digit;
  logic                 done;
  logic                 accept;

  // Divide by ten via reciprocal; remainder needs only the low nibble
  assign prod     = (2*VALUE_W)'(rest) * (2*VALUE_W)'(DIV10_MAGIC);
  assign quot     = VALUE_W'(prod >> DIV10_SHIFT);
  assign ten_q_lo = DIGIT_W'({quot[DIGIT_W-1:0], 3'b000} + {quot[DIGIT_W-1:0], 1'b0});
  assign digit    = rest[DIGIT_W-1:0] - ten_q_lo;
  assign done     = (quot == '0) || (k == IDX_W'(DIGIT_COUNT - 1));
  assign accept   = values.valid && values.ready;

  always_comb begin
    state_next = state;
    case (state)
      FRONT_IDLE: begin
        if (values.valid) state_next = FRONT_CONVERT;
      end
      FRONT_CONVERT: begin
        if (done) state_next = FRONT_PUSH;
      end
      FRONT_PUSH: begin
        if (!status.full) state_next = values.valid ? FRONT_CONVERT : FRONT_IDLE;
      end
      default: state_next = FRONT_IDLE;
    endcase
  end

  always_comb begin
    values.ready = 1'b0;
    push         = 1'b0;
    case (state)
      FRONT_IDLE: values.ready = 1'b1;
      FRONT_PUSH: begin
        values.ready = !status.full;
        push         = !status.full;
      end
      default: begin
        values.ready = 1'b0;
        push         = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rest      <= values.value;
      k         <= '0;
      top_count <= CNT_W'(1);
    end else if (state == FRONT_CONVERT) begin
      digs[k] <= digit;
      if (digit != '0) top_count <= CNT_W'(k) + CNT_W'(1);
      rest <= quot;
      if (!done) k <= k + IDX_W'(1);
    end
  end

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_pack
    assign rec[DIGIT_W*i +: DIGIT_W] = digs[i];
  end
  assign rec[REC_W-1 -: CNT_W] = top_count;

  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
      (state == FRONT_CONVERT) |-> (top_count <= CNT_W'(k) + CNT_W'(1)))
    else $error("top digit beyond digits produced");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
      push |-> (top_count != '0) && (top_count <= CNT_W'(DIGIT_COUNT)))
    else $error("queued digit count out of range");

endmodule

FILE: hdl/b2da_back.sv
// ----------------------------------------------------------------------------
// b2da_back
// Emit queued digits most significant first through an output register.
// ----------------------------------------------------------------------------
module b2da_back #(
  parameter int DIGIT_COUNT = b2da_pkg::DIGIT_COUNT_DEFAULT,
  parameter int REC_W       = 4 * DIGIT_COUNT + $clog2(DIGIT_COUNT + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [REC_W-1:0]        rec,
  input  b2da_pkg::queue_status_t status,
  output logic                    pop,
  b2da_char_if.source             chars
);
  import b2da_pkg::*;

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int CNT_W = $clog2(DIGIT_COUNT + 1);

  logic [DIGIT_W-1:0] digs [DIGIT_COUNT];
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   sent;
  logic [CNT_W-1:0]   pos;
  logic               is_last;
  logic               load;

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_unpack
    assign digs[i] = rec[DIGIT_W*i +: DIGIT_W];
  end
  assign count = rec[REC_W-1 -: CNT_W];

  assign pos     = count - CNT_W'(1) - CNT_W'(sent);
  assign is_last = (pos == '0);
  assign load    = !status.empty && (!chars.valid || chars.ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      sent        <= '0;
    end else begin
      if (load) begin
        chars.valid <= 1'b1;
        sent        <= is_last ? '0 : sent + IDX_W'(1);
      end else if (chars.ready) begin
        chars.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars.digit_char <= ASCII_ZERO + CHAR_W'(digs[pos[IDX_W-1:0]]);
      chars.last       <= is_last;
    end
  end

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
      pop |=> chars.valid && chars.last)
    else $error("record retired without a final character");
  a_sent_bound: assert property (@(posedge clk) disable iff (rst)
      !status.empty |-> (CNT_W'(sent) < count))
    else $error("emit position past top digit");

endmodule

FILE: hdl/binary_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Flow: the front peels digits off an accepted value, one divide-by-ten multiply
//   per cycle until the quotient is zero or DIGIT_COUNT digits are made, queues
//   the record and takes the next value unless the queue is full; the back sends
//   one character per cycle while a record is queued and chars.ready is high.
// Reset: synchronous rst empties the queue and drops any pending character.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core #(
  parameter int DIGIT_COUNT = b2da_pkg::DIGIT_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  b2da_value_if.sink  values,
  b2da_char_if.source chars
);
  import b2da_pkg::*;

  // Queue record: digit count on top, then DIGIT_COUNT nibbles, lowest digit at bit 0
  localparam int CNT_W = $clog2(DIGIT_COUNT + 1);
  localparam int REC_W = DIGIT_W * DIGIT_COUNT + CNT_W;

  logic               push;
  logic               pop;
  logic [REC_W-1:0]   wr_rec;
  logic [REC_W-1:0]   rd_rec;
  queue_status_t      status;

  // Front: take a transaction, peel digits low first, record the top digit
  b2da_front #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .REC_W       (REC_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .values (values),
    .status (status),
    .push   (push),
    .rec    (wr_rec)
  );

  // Queue: lets the front start the next value while the back still emits
  b2da_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_rec),
    .pop     (pop),
    .rd_data (rd_rec),
    .status  (status)
  );

  // Back: walk the head record from its top digit down, one transaction per
  // character; retire the record with the final digit
  b2da_back #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .REC_W       (REC_W)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .rec    (rd_rec),
    .status (status),
    .pop    (pop),
    .chars  (chars)
  );

endmodule
